>>> hdl/kmmh_pkg.sv
// kmmh_pkg: shared types, widths and the heap compare function for the k-way merge block
// used by kway_merge_min_heap and kmmh_checker; no dependencies
package kmmh_pkg;

   // item field widths
   localparam int KEY_W  = 64;
   localparam int ROW_W  = 64;
   localparam int RUN_W  = 5;   // run tag as loaded, follows the width of num_runs
   localparam int NEXT_W = 4;   // run tag as shown on the result item
   localparam int CFG_W  = 5;

   // stream payload widths
   localparam int REQ_DATA_W = KEY_W + ROW_W;
   localparam int RSP_DATA_W = ((ROW_W + KEY_W + NEXT_W + 7) / 8) * 8;

   // defaults
   localparam int               MAX_RUNS_DEF = 16;
   localparam logic [CFG_W-1:0] NUM_RUNS_RST = CFG_W'(2);

   // one heap slot
   typedef struct packed {
      logic [RUN_W-1:0]        run;
      logic [ROW_W-1:0]        row;
      logic signed [KEY_W-1:0] key;
   } entry_type;

   // true when slot c must sit above slot p; with two runs a tie goes to the higher run
   function automatic logic beats(entry_type c, entry_type p, logic pair);
      logic lt;
      logic tie;
      lt  = (c.key < p.key);
      tie = pair && (c.key == p.key) && (c.run > p.run);
      return lt || tie;
   endfunction

endpackage

>>> hdl/kway_merge_min_heap.sv
// kway_merge_min_heap: k-way merge of key-sorted runs over a binary min-heap
// depends on kmmh_pkg; heap slots live in a two-read, one-write memory
//
// The block merges num_runs sorted runs into one stream. First the head of each run (or an
// end marker, tuser high) is sent in run order; every load item but the last gives no
// result. After the last one the heap is built and the smallest head comes out, with the
// run that must supply the next item; each later item is that run's next element or its
// end marker, and gives exactly one result. A result with tuser low and tlast high means
// every run has ended. A merge item sinks the new head through the heap; an end marker
// first fetches the last slot, which then sinks from the root in its place. The final
// load item is followed by the heap build and then the result. The heap memory sets the
// pace: each level is a registered read of both children followed by a compare and
// write. The block accepts no item until the current one is done; a finished result may
// wait in the output register while the next item is taken. num_runs of 0 acts as 1 and
// values above MAX_RUNS act as MAX_RUNS; write it only while idle.
module kway_merge_min_heap #(
   parameter int MAX_RUNS = kmmh_pkg::MAX_RUNS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [kmmh_pkg::CFG_W-1:0]        csr_wr_data,
   // input items
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kmmh_pkg::REQ_DATA_W-1:0]   req_tdata,   // key [63:0], row_id [127:64]
   input  logic                              req_tuser,   // mode
   // result items
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kmmh_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // out_row_id, out_key, next_run, pad
   output logic                              rsp_tuser,   // has_item
   output logic                              rsp_tlast    // done_res
);

   localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
   localparam int LW = $clog2(MAX_RUNS + 1);
   localparam int CW = AW + 2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BLD_RD,
      S_BLD_LD,
      S_LAST_RD,
      S_LAST_LD,
      S_SIFT_RD,
      S_SIFT_CMP,
      S_EMIT
   } state_type;

   // control state
   state_type                     state_ff, state_in;
   logic [kmmh_pkg::CFG_W-1:0]    num_runs_ff, num_runs_in;
   logic [LW-1:0]                 live_ff, live_in;
   logic [kmmh_pkg::RUN_W-1:0]    load_idx_ff, load_idx_in;
   logic                          phase_ff, phase_in;
   logic                          build_ff, build_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // datapath state
   kmmh_pkg::entry_type           hold_ff, hold_in;   // element being sifted
   kmmh_pkg::entry_type           root_ff;            // copy of slot 0
   logic [AW-1:0]                 cur_ff, cur_in;
   logic [AW-1:0]                 bld_ff, bld_in;
   logic [kmmh_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_user_ff, rsp_user_in;
   logic                          rsp_last_ff, rsp_last_in;

   // heap memory
   kmmh_pkg::entry_type           heap_mem [MAX_RUNS];
   kmmh_pkg::entry_type           rd_a_ff, rd_b_ff;
   logic [AW-1:0]                 rd_a_addr, rd_b_addr, wr_addr;
   kmmh_pkg::entry_type           wr_data;
   logic                          wr_en;

   // combinational helpers
   logic [kmmh_pkg::CFG_W-1:0]    eff_runs;
   logic                          pair;
   logic                          accept;
   logic                          in_mode;
   kmmh_pkg::entry_type           in_entry;
   logic [CW-1:0]                 l_idx, r_idx, bl_idx;
   logic                          have_l, have_r, bld_has_kid;
   logic                          beat_l, beat_r;
   logic                          has_space;
   logic [kmmh_pkg::RUN_W:0]      load_next;

   // effective run count and tie rule
   always_comb begin
      priority if (num_runs_ff == '0) begin
         eff_runs = kmmh_pkg::CFG_W'(1);
      end else if (int'(num_runs_ff) > MAX_RUNS) begin
         eff_runs = kmmh_pkg::CFG_W'(MAX_RUNS);
      end else begin
         eff_runs = num_runs_ff;
      end
   end
   assign pair = (eff_runs == kmmh_pkg::CFG_W'(2));

   // input unpacking
   assign accept       = req_tvalid && req_tready;
   assign in_mode      = req_tuser;
   assign in_entry.key = req_tdata[kmmh_pkg::KEY_W-1:0];
   assign in_entry.row = req_tdata[kmmh_pkg::REQ_DATA_W-1:kmmh_pkg::KEY_W];
   assign in_entry.run = load_idx_ff;
   assign has_space    = int'(live_ff) < MAX_RUNS;
   assign load_next    = {1'b0, load_idx_ff} + (kmmh_pkg::RUN_W + 1)'(1);

   // child indexes of the current slot and of the build start slot
   assign l_idx       = (CW'(cur_ff) << 1) + CW'(1);
   assign r_idx       = (CW'(cur_ff) << 1) + CW'(2);
   assign bl_idx      = (CW'(bld_ff) << 1) + CW'(1);
   assign have_l      = int'(l_idx) < int'(live_ff);
   assign have_r      = int'(r_idx) < int'(live_ff);
   assign bld_has_kid = int'(bl_idx) < int'(live_ff);

   // one level of the sift: pick the smallest of the held element and both children
   always_comb begin
      beat_l = have_l && kmmh_pkg::beats(rd_a_ff, hold_ff, pair);
      if (beat_l) begin
         beat_r = have_r && kmmh_pkg::beats(rd_b_ff, rd_a_ff, pair);
      end else begin
         beat_r = have_r && kmmh_pkg::beats(rd_b_ff, hold_ff, pair);
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   // sequencer next state and memory port control
   always_comb begin
      state_in     = state_ff;
      num_runs_in  = csr_wr_en ? csr_wr_data : num_runs_ff;
      live_in      = live_ff;
      load_idx_in  = load_idx_ff;
      phase_in     = phase_ff;
      build_in     = build_ff;
      hold_in      = hold_ff;
      cur_in       = cur_ff;
      bld_in       = bld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      rd_a_addr    = l_idx[AW-1:0];
      rd_b_addr    = r_idx[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = hold_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!phase_ff) begin
                  // load the head of the next run
                  if (!in_mode && has_space) begin
                     wr_en   = 1'b1;
                     wr_addr = live_ff[AW-1:0];
                     wr_data = in_entry;
                     live_in = live_ff + LW'(1);
                  end
                  load_idx_in = load_next[kmmh_pkg::RUN_W-1:0];
                  if (load_next >= {1'b0, eff_runs}) begin
                     phase_in = 1'b1;
                     build_in = 1'b1;
                     if (!in_mode && has_space) begin
                        bld_in = AW'((live_ff + LW'(1)) >> 1);
                     end else begin
                        bld_in = AW'(live_ff >> 1);
                     end
                     state_in = S_BLD_RD;
                  end
               end else if (live_ff == '0) begin
                  state_in = S_EMIT;
               end else if (!in_mode) begin
                  // new head of the root's run replaces the root
                  hold_in.key = in_entry.key;
                  hold_in.row = in_entry.row;
                  hold_in.run = root_ff.run;
                  cur_in      = '0;
                  build_in    = 1'b0;
                  state_in    = S_SIFT_RD;
               end else begin
                  // root's run ended: the last slot moves up
                  live_in  = live_ff - LW'(1);
                  build_in = 1'b0;
                  cur_in   = '0;
                  if (live_ff == LW'(1)) begin
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_LAST_RD;
                  end
               end
            end
         end
         S_BLD_RD: begin
            rd_a_addr = bld_ff;
            if (bld_has_kid) begin
               state_in = S_BLD_LD;
            end else if (bld_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               bld_in = bld_ff - AW'(1);
            end
         end
         S_BLD_LD: begin
            hold_in  = rd_a_ff;
            cur_in   = bld_ff;
            state_in = S_SIFT_RD;
         end
         S_LAST_RD: begin
            rd_a_addr = live_ff[AW-1:0];
            state_in  = S_LAST_LD;
         end
         S_LAST_LD: begin
            hold_in  = rd_a_ff;
            state_in = S_SIFT_RD;
         end
         S_SIFT_RD: begin
            if (have_l) begin
               state_in = S_SIFT_CMP;
            end else begin
               // leaf reached: park the held element
               wr_en = 1'b1;
               if (build_ff && bld_ff != '0) begin
                  bld_in   = bld_ff - AW'(1);
                  state_in = S_BLD_RD;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_SIFT_CMP: begin
            wr_en = 1'b1;
            priority if (beat_r) begin
               wr_data  = rd_b_ff;
               cur_in   = r_idx[AW-1:0];
               state_in = S_SIFT_RD;
            end else if (beat_l) begin
               wr_data  = rd_a_ff;
               cur_in   = l_idx[AW-1:0];
               state_in = S_SIFT_RD;
            end else if (build_ff && bld_ff != '0) begin
               bld_in   = bld_ff - AW'(1);
               state_in = S_BLD_RD;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (live_ff != '0) begin
                  rsp_user_in = 1'b1;
                  rsp_last_in = 1'b0;
                  rsp_data_in = kmmh_pkg::RSP_DATA_W'({root_ff.run[kmmh_pkg::NEXT_W-1:0],
                                                      root_ff.key, root_ff.row});
               end else begin
                  rsp_user_in = 1'b0;
                  rsp_last_in = 1'b1;
                  rsp_data_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // heap memory with registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_a_addr];
      rd_b_ff <= heap_mem[rd_b_addr];
   end

   // sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         num_runs_ff  <= kmmh_pkg::NUM_RUNS_RST;
         live_ff      <= '0;
         load_idx_ff  <= '0;
         phase_ff     <= 1'b0;
         build_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_runs_ff  <= num_runs_in;
         live_ff      <= live_in;
         load_idx_ff  <= load_idx_in;
         phase_ff     <= phase_in;
         build_ff     <= build_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_ff     <= hold_in;
      cur_ff      <= cur_in;
      bld_ff      <= bld_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      // slot 0 copy follows every write to the root
      if (wr_en && wr_addr == '0) begin
         root_ff <= wr_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> hdl/kmmh_checker.sv
// kmmh_checker: port-level checks on the result stream of the k-way merge block
// depends on kmmh_pkg; bound to kway_merge_min_heap at the end of this file
module kmmh_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [kmmh_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // an emitted element never carries the finished flag
   a_item_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast)
      else $error("element emitted with finished flag");

   // an item without an element only ever reports the end of the merge
   a_empty_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("empty result item is not a clean end report");

   // once finished, the next result is finished too
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast ##1 rsp_tvalid |-> rsp_tlast)
      else $error("element emitted after the merge finished");

endmodule

bind kway_merge_min_heap kmmh_checker u_kmmh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
